[sv/bmi_pkg.sv]
// Shared types and constants of the Bareiss matrix inverter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bmi_pkg;

	localparam int DATA_W = 64;
	localparam int PROD_W = 128;
	localparam int INV_W = 48;
	localparam int FRAC_BITS = 16;
	localparam int SIZE_W = 4;
	localparam int STATUS_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_DET = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_PIV = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVF = 2'd3;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_LOAD_ENTRY = 4'd1;
	localparam op_t OP_WRITE_CONST = 4'd2;
	localparam op_t OP_INIT = 4'd3;
	localparam op_t OP_MUL_A = 4'd4;
	localparam op_t OP_MUL_B = 4'd5;
	localparam op_t OP_SUB = 4'd6;
	localparam op_t OP_DIV_ELIM = 4'd7;
	localparam op_t OP_ELIM_FIN = 4'd8;
	localparam op_t OP_WRITE_RES = 4'd9;
	localparam op_t OP_NEXT_PIVOT = 4'd10;
	localparam op_t OP_DIV_Q16 = 4'd11;
	localparam op_t OP_Q16_RND = 4'd12;
	localparam op_t OP_Q16_INC = 4'd13;
	localparam op_t OP_Q16_SAT = 4'd14;
	localparam op_t OP_OUT_LOAD = 4'd15;

	typedef logic [2:0] ld_t;
	localparam ld_t LD_NONE = 3'd0;
	localparam ld_t LD_PIV = 3'd1;
	localparam ld_t LD_FAC = 3'd2;
	localparam ld_t LD_A = 3'd3;
	localparam ld_t LD_B = 3'd4;
	localparam ld_t LD_ADJ = 3'd5;

	typedef struct packed {
		op_t op;
		ld_t ld;
		logic const_one;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic piv_zero;
		logic ovf;
	} stat_t;

endpackage

`default_nettype wire

[sv/bmi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
`default_nettype none

module bmi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/bmi_mul.sv]
// Signed 64 x 64 multiplier built from four 32 x 32 partial products over cycles.
// Self-contained; no package needed.
`default_nettype none

module bmi_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] x,
	input wire logic [63:0] y,
	output logic [127:0] p,
	output logic done
);

	logic busy_q;
	logic [2:0] step_q;
	logic done_q;
	logic [63:0] mx_q, my_q, pp_q;
	logic neg_q;
	logic [1:0] psh_q;
	logic [127:0] acc_q, p_q, pp_ext;
	logic [31:0] a_part, b_part;

	assign a_part = step_q[1] ? mx_q[63:32] : mx_q[31:0];
	assign b_part = step_q[0] ? my_q[63:32] : my_q[31:0];

	always_comb begin
		case (psh_q)
			2'd0: pp_ext = {64'b0, pp_q};
			2'd1: pp_ext = {32'b0, pp_q, 32'b0};
			default: pp_ext = {pp_q, 64'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mx_q <= x[63] ? 64'(-x) : x;
			my_q <= y[63] ? 64'(-y) : y;
			neg_q <= x[63] ^ y[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q <= 3'd3) begin
				pp_q <= 64'(a_part) * 64'(b_part);
				psh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
			end
			// Each partial product is registered in pp_q before it is added to the accumulator.
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				acc_q <= acc_q + pp_ext;
			end
			if (step_q == 3'd5) begin
				p_q <= neg_q ? 128'(-acc_q) : acc_q;
			end
		end
	end

	assign p = p_q;
	assign done = done_q;

endmodule

`default_nettype wire

[sv/bmi_div.sv]
// Bit-serial unsigned 128 / 64 restoring divider, one quotient bit per cycle.
// Self-contained; no package needed.
`default_nettype none

module bmi_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [127:0] num,
	input wire logic [63:0] den,
	output logic [127:0] quo,
	output logic [63:0] rem,
	output logic done
);

	logic busy_q, done_q;
	logic [6:0] cnt_q;
	logic [127:0] nq_q;
	logic [63:0] r_q, d_q;
	logic [64:0] rw, rn;
	logic ge;

	assign rw = {r_q, nq_q[127]};
	assign ge = rw >= {1'b0, d_q};
	assign rn = ge ? rw - {1'b0, d_q} : rw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The numerator shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			r_q <= rn[63:0];
			nq_q <= {nq_q[126:0], ge};
		end
	end

	assign quo = nq_q;
	assign rem = r_q;
	assign done = done_q;

endmodule

`default_nettype wire

[sv/bmi_datapath.sv]
// Datapath of the inverter: augmented-matrix RAM, operand registers, multiplier,
// divider and result formatting. Uses bmi_pkg, bmi_ram, bmi_mul and bmi_div.
`default_nettype none

module bmi_datapath #(
	parameter int MAX_DIM = 8,
	parameter int ENTRY_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bmi_pkg::cmd_t cmd,
	input wire logic [$clog2(MAX_DIM)+$clog2(2*MAX_DIM)-1:0] addr,
	input wire logic [ENTRY_BITS-1:0] entry,
	output bmi_pkg::stat_t stat,
	output logic [63:0] adj_out,
	output logic [63:0] det_out,
	output logic [47:0] inv_out
);

	localparam int AW = $clog2(MAX_DIM) + $clog2(2 * MAX_DIM);
	localparam int DEPTH = 2 ** AW;

	logic ram_we;
	logic [63:0] ram_wdata, ram_rdata;
	logic [63:0] piv_q, prev_q, fac_q, a_q, b_q, adj_q, res_q, dmag_q;
	logic [127:0] prod1_q, t_q, qr_q, t_mag;
	logic sign_q, ovf_q, rnd_q;
	logic [47:0] inv_q;
	logic [63:0] adj_o_q, det_o_q;
	logic [47:0] inv_o_q;
	logic mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_x, mul_y, div_den, div_rem, adj_mag, prev_mag;
	logic [127:0] mul_p, div_num, div_quo;
	logic [63:0] lim64;
	logic [47:0] lim48, sat48;
	logic elim_ovf;

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = res_q;
		case (cmd.op)
			bmi_pkg::OP_LOAD_ENTRY: begin
				ram_we = 1'b1;
				ram_wdata = {{(64 - ENTRY_BITS){entry[ENTRY_BITS-1]}}, entry};
			end
			bmi_pkg::OP_WRITE_CONST: begin
				ram_we = 1'b1;
				ram_wdata = {63'b0, cmd.const_one};
			end
			bmi_pkg::OP_WRITE_RES: begin
				ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	bmi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(addr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	assign mul_start = (cmd.op == bmi_pkg::OP_MUL_A) || (cmd.op == bmi_pkg::OP_MUL_B);
	assign mul_x = (cmd.op == bmi_pkg::OP_MUL_A) ? a_q : b_q;
	assign mul_y = (cmd.op == bmi_pkg::OP_MUL_A) ? piv_q : fac_q;

	bmi_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.x(mul_x),
		.y(mul_y),
		.p(mul_p),
		.done(mul_done)
	);

	assign t_mag = t_q[127] ? 128'(-t_q) : t_q;
	assign adj_mag = adj_q[63] ? 64'(-adj_q) : adj_q;
	assign prev_mag = prev_q[63] ? 64'(-prev_q) : prev_q;
	assign div_start = (cmd.op == bmi_pkg::OP_DIV_ELIM) || (cmd.op == bmi_pkg::OP_DIV_Q16);
	assign div_num = (cmd.op == bmi_pkg::OP_DIV_ELIM) ? t_mag : {48'b0, adj_mag, 16'b0};
	assign div_den = prev_mag;

	bmi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quo(div_quo),
		.rem(div_rem),
		.done(div_done)
	);

	// A quotient must fit signed 64 bits; the negative side reaches one further.
	assign lim64 = sign_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	assign elim_ovf = (div_quo[127:64] != 64'b0) || (div_quo[63:0] > lim64);
	assign lim48 = sign_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	assign sat48 = ((qr_q[127:48] != 80'b0) || (qr_q[47:0] > lim48)) ? lim48 : qr_q[47:0];

	always_ff @(posedge clk) begin
		case (cmd.ld)
			bmi_pkg::LD_PIV: piv_q <= ram_rdata;
			bmi_pkg::LD_FAC: fac_q <= ram_rdata;
			bmi_pkg::LD_A: a_q <= ram_rdata;
			bmi_pkg::LD_B: b_q <= ram_rdata;
			bmi_pkg::LD_ADJ: adj_q <= ram_rdata;
			default: ;
		endcase
		case (cmd.op)
			bmi_pkg::OP_INIT: prev_q <= 64'd1;
			bmi_pkg::OP_MUL_B: prod1_q <= mul_p;
			bmi_pkg::OP_SUB: t_q <= prod1_q - mul_p;
			bmi_pkg::OP_DIV_ELIM: sign_q <= t_q[127] ^ prev_q[63];
			bmi_pkg::OP_ELIM_FIN: begin
				res_q <= sign_q ? 64'(-div_quo[63:0]) : div_quo[63:0];
			end
			bmi_pkg::OP_NEXT_PIVOT: prev_q <= piv_q;
			bmi_pkg::OP_DIV_Q16: begin
				sign_q <= adj_q[63] ^ prev_q[63];
				dmag_q <= prev_mag;
			end
			// Round to nearest, ties away from zero, on magnitudes.
			bmi_pkg::OP_Q16_RND: rnd_q <= div_rem >= (dmag_q - div_rem);
			bmi_pkg::OP_Q16_INC: qr_q <= div_quo + {127'b0, rnd_q};
			bmi_pkg::OP_Q16_SAT: inv_q <= sign_q ? 48'(-sat48) : sat48;
			bmi_pkg::OP_OUT_LOAD: begin
				adj_o_q <= cmd.status[1] ? 64'b0 : adj_q;
				det_o_q <= cmd.status[1] ? 64'b0 : prev_q;
				inv_o_q <= (cmd.status != bmi_pkg::ST_OK) ? 48'b0 : inv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.op == bmi_pkg::OP_ELIM_FIN) begin
			ovf_q <= elim_ovf;
		end
	end

	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.piv_zero = piv_q == 64'b0;
	assign stat.ovf = ovf_q;
	assign adj_out = adj_o_q;
	assign det_out = det_o_q;
	assign inv_out = inv_o_q;

endmodule

`default_nettype wire

[sv/bmi_ctrl.sv]
// Controller of the inverter: load counters, elimination loops over pivot, row
// and column, and the result sequence. Uses bmi_pkg; drives bmi_datapath.
`default_nettype none

module bmi_ctrl #(
	parameter int MAX_DIM = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write_en,
	input wire logic [3:0] cfg_write_data,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output logic last_result,
	output logic [1:0] status,
	input wire bmi_pkg::stat_t stat,
	output bmi_pkg::cmd_t cmd,
	output logic [$clog2(MAX_DIM)+$clog2(2*MAX_DIM)-1:0] addr
);

	localparam int RB = $clog2(MAX_DIM);
	localparam int CB = $clog2(2 * MAX_DIM);
	localparam int NB = $clog2(MAX_DIM + 1);

	localparam logic [4:0] S_LOAD = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_IDENT = 5'd2;
	localparam logic [4:0] S_PIV_RD = 5'd3;
	localparam logic [4:0] S_PIV_LD = 5'd4;
	localparam logic [4:0] S_PIV_CHK = 5'd5;
	localparam logic [4:0] S_ROW = 5'd6;
	localparam logic [4:0] S_FAC_LD = 5'd7;
	localparam logic [4:0] S_CELL_RDA = 5'd8;
	localparam logic [4:0] S_CELL_RDB = 5'd9;
	localparam logic [4:0] S_CELL_LDB = 5'd10;
	localparam logic [4:0] S_MUL_A = 5'd11;
	localparam logic [4:0] S_MUL_B = 5'd12;
	localparam logic [4:0] S_DIV_GO = 5'd13;
	localparam logic [4:0] S_DIV_W = 5'd14;
	localparam logic [4:0] S_CELL_WR = 5'd15;
	localparam logic [4:0] S_PIV_NEXT = 5'd16;
	localparam logic [4:0] S_OUT = 5'd17;
	localparam logic [4:0] S_ADJ_LD = 5'd18;
	localparam logic [4:0] S_Q_GO = 5'd19;
	localparam logic [4:0] S_Q_W = 5'd20;
	localparam logic [4:0] S_Q_INC = 5'd21;
	localparam logic [4:0] S_Q_SAT = 5'd22;
	localparam logic [4:0] S_OUT_LD = 5'd23;
	localparam logic [4:0] S_OUT_V = 5'd24;

	logic [4:0] state_q, state_d;
	logic [3:0] size_q;
	logic [RB-1:0] lrow_q, lrow_d, lcol_q, lcol_d, p_q, p_d, i_q, i_d, r_q, r_d, c_q, c_d;
	logic [CB-1:0] j_q, j_d;
	logic [1:0] status_q, status_d;
	logic [NB-1:0] n_eff;
	logic [RB-1:0] n_m1;
	logic [CB-1:0] twon_m1, aug_col, p_col;
	logic last_out;

	// A size of zero acts as one; a size beyond the largest acts as the largest.
	always_comb begin
		if (size_q == 4'd0) begin
			n_eff = NB'(1);
		end else if (32'(size_q) > MAX_DIM) begin
			n_eff = NB'(MAX_DIM);
		end else begin
			n_eff = NB'(size_q);
		end
	end

	assign n_m1 = RB'(n_eff - NB'(1));
	assign twon_m1 = CB'({n_eff, 1'b0}) - CB'(1);
	assign aug_col = CB'(n_eff) + CB'(c_q);
	assign p_col = CB'(p_q);
	assign last_out = (r_q == n_m1) && (c_q == n_m1);

	always_comb begin
		state_d = state_q;
		lrow_d = lrow_q;
		lcol_d = lcol_q;
		p_d = p_q;
		i_d = i_q;
		j_d = j_q;
		r_d = r_q;
		c_d = c_q;
		status_d = status_q;
		cmd.op = bmi_pkg::OP_NONE;
		cmd.ld = bmi_pkg::LD_NONE;
		cmd.const_one = 1'b0;
		cmd.status = status_q;
		addr = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				addr = {lrow_q, CB'(lcol_q)};
				if (in_valid) begin
					cmd.op = bmi_pkg::OP_LOAD_ENTRY;
					if (lcol_q == n_m1) begin
						lcol_d = '0;
						if (lrow_q == n_m1) begin
							lrow_d = '0;
							state_d = S_START;
						end else begin
							lrow_d = lrow_q + RB'(1);
						end
					end else begin
						lcol_d = lcol_q + RB'(1);
					end
				end
			end
			S_START: begin
				cmd.op = bmi_pkg::OP_INIT;
				r_d = '0;
				c_d = '0;
				state_d = S_IDENT;
			end
			S_IDENT: begin
				cmd.op = bmi_pkg::OP_WRITE_CONST;
				cmd.const_one = r_q == c_q;
				addr = {r_q, aug_col};
				if (c_q == n_m1) begin
					c_d = '0;
					if (r_q == n_m1) begin
						r_d = '0;
						p_d = '0;
						state_d = S_PIV_RD;
					end else begin
						r_d = r_q + RB'(1);
					end
				end else begin
					c_d = c_q + RB'(1);
				end
			end
			S_PIV_RD: begin
				addr = {p_q, p_col};
				state_d = S_PIV_LD;
			end
			S_PIV_LD: begin
				cmd.ld = bmi_pkg::LD_PIV;
				state_d = S_PIV_CHK;
			end
			S_PIV_CHK: begin
				// Only the final pivot may be zero; that case yields a zero determinant.
				if (stat.piv_zero && (p_q != n_m1)) begin
					status_d = bmi_pkg::ST_ZERO_PIV;
					r_d = '0;
					c_d = '0;
					state_d = S_OUT;
				end else begin
					i_d = '0;
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				if (i_q == p_q) begin
					if (i_q == n_m1) begin
						state_d = S_PIV_NEXT;
					end else begin
						i_d = i_q + RB'(1);
					end
				end else begin
					addr = {i_q, p_col};
					state_d = S_FAC_LD;
				end
			end
			S_FAC_LD: begin
				cmd.ld = bmi_pkg::LD_FAC;
				j_d = p_col + CB'(1);
				state_d = S_CELL_RDA;
			end
			S_CELL_RDA: begin
				addr = {i_q, j_q};
				state_d = S_CELL_RDB;
			end
			S_CELL_RDB: begin
				cmd.ld = bmi_pkg::LD_A;
				addr = {p_q, j_q};
				state_d = S_CELL_LDB;
			end
			S_CELL_LDB: begin
				cmd.ld = bmi_pkg::LD_B;
				cmd.op = bmi_pkg::OP_MUL_A;
				state_d = S_MUL_A;
			end
			S_MUL_A: begin
				if (stat.mul_done) begin
					cmd.op = bmi_pkg::OP_MUL_B;
					state_d = S_MUL_B;
				end
			end
			S_MUL_B: begin
				if (stat.mul_done) begin
					cmd.op = bmi_pkg::OP_SUB;
					state_d = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				cmd.op = bmi_pkg::OP_DIV_ELIM;
				state_d = S_DIV_W;
			end
			S_DIV_W: begin
				if (stat.div_done) begin
					cmd.op = bmi_pkg::OP_ELIM_FIN;
					state_d = S_CELL_WR;
				end
			end
			S_CELL_WR: begin
				if (stat.ovf) begin
					status_d = bmi_pkg::ST_OVF;
					r_d = '0;
					c_d = '0;
					state_d = S_OUT;
				end else begin
					cmd.op = bmi_pkg::OP_WRITE_RES;
					addr = {i_q, j_q};
					if (j_q == twon_m1) begin
						if (i_q == n_m1) begin
							state_d = S_PIV_NEXT;
						end else begin
							i_d = i_q + RB'(1);
							state_d = S_ROW;
						end
					end else begin
						j_d = j_q + CB'(1);
						state_d = S_CELL_RDA;
					end
				end
			end
			S_PIV_NEXT: begin
				cmd.op = bmi_pkg::OP_NEXT_PIVOT;
				if (p_q == n_m1) begin
					status_d = stat.piv_zero ? bmi_pkg::ST_ZERO_DET : bmi_pkg::ST_OK;
					r_d = '0;
					c_d = '0;
					state_d = S_OUT;
				end else begin
					p_d = p_q + RB'(1);
					state_d = S_PIV_RD;
				end
			end
			S_OUT: begin
				if ((status_q == bmi_pkg::ST_ZERO_PIV) || (status_q == bmi_pkg::ST_OVF)) begin
					state_d = S_OUT_LD;
				end else begin
					addr = {r_q, aug_col};
					state_d = S_ADJ_LD;
				end
			end
			S_ADJ_LD: begin
				cmd.ld = bmi_pkg::LD_ADJ;
				state_d = (status_q == bmi_pkg::ST_OK) ? S_Q_GO : S_OUT_LD;
			end
			S_Q_GO: begin
				cmd.op = bmi_pkg::OP_DIV_Q16;
				state_d = S_Q_W;
			end
			S_Q_W: begin
				if (stat.div_done) begin
					cmd.op = bmi_pkg::OP_Q16_RND;
					state_d = S_Q_INC;
				end
			end
			S_Q_INC: begin
				cmd.op = bmi_pkg::OP_Q16_INC;
				state_d = S_Q_SAT;
			end
			S_Q_SAT: begin
				cmd.op = bmi_pkg::OP_Q16_SAT;
				state_d = S_OUT_LD;
			end
			S_OUT_LD: begin
				cmd.op = bmi_pkg::OP_OUT_LOAD;
				state_d = S_OUT_V;
			end
			S_OUT_V: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (last_out) begin
						state_d = S_LOAD;
					end else begin
						state_d = S_OUT;
						if (c_q == n_m1) begin
							c_d = '0;
							r_d = r_q + RB'(1);
						end else begin
							c_d = c_q + RB'(1);
						end
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			size_q <= bmi_pkg::SIZE_RESET;
			lrow_q <= '0;
			lcol_q <= '0;
			p_q <= '0;
			i_q <= '0;
			j_q <= '0;
			r_q <= '0;
			c_q <= '0;
			status_q <= bmi_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			p_q <= p_d;
			i_q <= i_d;
			j_q <= j_d;
			r_q <= r_d;
			c_q <= c_d;
			status_q <= status_d;
			// A size write discards a partly loaded matrix.
			if (cfg_write_en) begin
				size_q <= cfg_write_data;
				lrow_q <= '0;
				lcol_q <= '0;
			end else begin
				lrow_q <= lrow_d;
				lcol_q <= lcol_d;
			end
		end
	end

	assign last_result = (state_q == S_OUT_V) && last_out;
	assign status = status_q;

endmodule

`default_nettype wire

[sv/bareiss_matrix_inverse.sv]
// Fraction-free (Bareiss) integer matrix inverter, controller plus datapath.
// Loading accepts one entry per cycle while in_valid is high. Elimination then
// updates one cell at a time through the multiplier and the bit-serial 128-bit
// divider, and each result of a run with status OK takes its own Q16 division.
// One matrix is in work at a time. Asynchronous active-low reset returns to loading
// with size 8; the matrix RAM is not cleared. Uses bmi_pkg, bmi_ctrl, bmi_datapath.
`default_nettype none

module bareiss_matrix_inverse #(
	parameter int MAX_DIM = 8,
	parameter int ENTRY_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write_en,
	input wire logic [3:0] cfg_write_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [ENTRY_BITS-1:0] matrix_entry,
	output logic out_valid,
	input wire logic out_ready,
	output logic [63:0] adjugate_entry,
	output logic [63:0] determinant,
	output logic [47:0] inverse_q16,
	output logic [1:0] status,
	output logic last_result
);

	localparam int AW = $clog2(MAX_DIM) + $clog2(2 * MAX_DIM);

	bmi_pkg::cmd_t cmd;
	bmi_pkg::stat_t stat;
	logic [AW-1:0] addr;

	bmi_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.last_result(last_result),
		.status(status),
		.stat(stat),
		.cmd(cmd),
		.addr(addr)
	);

	bmi_datapath #(.MAX_DIM(MAX_DIM), .ENTRY_BITS(ENTRY_BITS)) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.addr(addr),
		.entry(matrix_entry),
		.stat(stat),
		.adj_out(adjugate_entry),
		.det_out(determinant),
		.inv_out(inverse_q16)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == bmi_pkg::ST_ZERO_PIV) || (status == bmi_pkg::ST_OVF)))
		|-> (adjugate_entry == 64'b0 && determinant == 64'b0 && inverse_q16 == 48'b0))
		else $error("failed run produced nonzero result fields");

	a_zero_det_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == bmi_pkg::ST_ZERO_DET)) |-> (inverse_q16 == 48'b0))
		else $error("inverse nonzero for a singular matrix");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> in_ready)
		else $error("block did not return to loading after the last result");
`endif

endmodule

`default_nettype wire

[bench/bareiss_matrix_inverse_checker.sv]
// Checker for the Bareiss matrix inverter: follows the size register and the input
// transactions, predicts every inverse entry and compares the output transactions.
// Depends on bmi_pkg for the status codes and the reset size.
`timescale 1ns / 100ps

module bareiss_matrix_inverse_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write_en,
	input wire logic [3:0] cfg_write_data,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [11:0] matrix_entry,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [63:0] adjugate_entry,
	input wire logic [63:0] determinant,
	input wire logic [47:0] inverse_q16,
	input wire logic [1:0] status,
	input wire logic last_result,
	output int pending,
	output int errors
);

	typedef struct {
		logic [63:0] adj;
		logic [63:0] det;
		logic [47:0] q16;
		logic [1:0] st;
		logic last;
	} inv_entry_t;

	inv_entry_t inverse_q[$];
	logic signed [63:0] cells[8][16];
	logic signed [63:0] last_pivot;
	logic [3:0] size_reg;
	int loaded;

	assign pending = inverse_q.size();

	function automatic logic [1:0] eliminate_cells(int n);
		logic signed [63:0] piv;
		logic signed [127:0] a, b, c, d, t;
		logic [127:0] mag, q, lim;
		logic [63:0] dm;
		logic qneg;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				cells[i][n+j] = (i == j) ? 64'sd1 : 64'sd0;
		last_pivot = 64'sd1;
		for (int p = 0; p < n; p++) begin
			piv = cells[p][p];
			if (piv == 0 && p + 1 < n)
				return bmi_pkg::ST_ZERO_PIV;
			for (int i = 0; i < n; i++) begin
				if (i == p)
					continue;
				for (int j = p + 1; j < 2 * n; j++) begin
					a = cells[i][j];
					b = piv;
					c = cells[p][j];
					d = cells[i][p];
					t = a * b - c * d;
					mag = t[127] ? -t : t;
					dm = last_pivot[63] ? -last_pivot : last_pivot;
					q = mag / {64'd0, dm};
					qneg = t[127] ^ last_pivot[63];
					lim = qneg ? (128'd1 << 63) : (128'd1 << 63) - 1;
					if (q > lim)
						return bmi_pkg::ST_OVF;
					cells[i][j] = qneg ? -q[63:0] : q[63:0];
				end
			end
			last_pivot = piv;
		end
		return (last_pivot == 0) ? bmi_pkg::ST_ZERO_DET : bmi_pkg::ST_OK;
	endfunction

	// Rounds to nearest with ties away from zero, then saturates to 48 bits.
	function automatic logic [47:0] scaled_inverse(logic signed [63:0] adj,
			logic signed [63:0] det);
		logic signed [127:0] num, a;
		logic [127:0] mag, dm, q, r, lim;
		logic neg;
		a = adj;
		num = a * 128'sd65536;
		mag = num[127] ? -num : num;
		dm = {64'd0, det[63] ? -det : det};
		q = mag / dm;
		r = mag % dm;
		if (r >= dm - r)
			q = q + 1;
		neg = num[127] ^ det[63];
		lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
		if (q > lim)
			q = lim;
		return neg ? -q[47:0] : q[47:0];
	endfunction

	task automatic predict_inverse(int n);
		logic [1:0] st;
		inv_entry_t e;
		st = eliminate_cells(n);
		for (int k = 0; k < n * n; k++) begin
			e.st = st;
			e.last = (k + 1 == n * n);
			if (st == bmi_pkg::ST_ZERO_PIV || st == bmi_pkg::ST_OVF) begin
				e.adj = '0;
				e.det = '0;
				e.q16 = '0;
			end else begin
				e.adj = cells[k / n][n + k % n];
				e.det = last_pivot;
				e.q16 = (st == bmi_pkg::ST_ZERO_DET) ? 48'd0 :
					scaled_inverse(cells[k / n][n + k % n], last_pivot);
			end
			inverse_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int n;
		inv_entry_t e;
		if (!arst_n) begin
			size_reg = bmi_pkg::SIZE_RESET;
			loaded = 0;
			errors = 0;
			inverse_q.delete();
		end else begin
			n = (size_reg == 0) ? 1 : (size_reg > 8) ? 8 : size_reg;
			if (in_valid && in_ready) begin
				if (loaded >= n * n)
					loaded = 0;
				cells[loaded / n][loaded % n] = $signed(matrix_entry);
				loaded++;
				if (loaded == n * n) begin
					loaded = 0;
					predict_inverse(n);
				end
			end
			if (cfg_write_en) begin
				size_reg = cfg_write_data;
				loaded = 0;
			end
			if (out_valid && out_ready) begin
				if (inverse_q.size() == 0) begin
					$display("%0t: result transaction with nothing expected", $time);
					errors++;
				end else begin
					e = inverse_q.pop_front();
					if (adjugate_entry !== e.adj || determinant !== e.det ||
							inverse_q16 !== e.q16 || status !== e.st ||
							last_result !== e.last) begin
						$display("%0t: expected adj=%0d det=%0d q16=%h st=%0d last=%0b",
							$time, $signed(e.adj), $signed(e.det), e.q16, e.st, e.last);
						$display("%0t:   actual adj=%0d det=%0d q16=%h st=%0d last=%0b",
							$time, $signed(adjugate_entry), $signed(determinant),
							inverse_q16, status, last_result);
						errors++;
					end
				end
			end
		end
	end
endmodule

[bench/bareiss_matrix_inverse_tb.sv]
// Top of the matrix inverter testbench: clock, reset, size writes and entry stimulus.
// Depends on bareiss_matrix_inverse and bareiss_matrix_inverse_checker.
`timescale 1ns / 100ps

module bareiss_matrix_inverse_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [3:0] cfg_write_data = 4'd0;
	logic in_valid = 1'b0;
	logic [11:0] matrix_entry = 12'd0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid, last_result;
	logic [63:0] adjugate_entry, determinant;
	logic [47:0] inverse_q16;
	logic [1:0] status;
	int pending, errors;
	int in_idle_pct = 25;
	int out_idle_pct = 59;
	int sent = 0;

	bareiss_matrix_inverse uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_ready(in_ready), .matrix_entry(matrix_entry),
		.out_valid(out_valid), .out_ready(out_ready),
		.adjugate_entry(adjugate_entry), .determinant(determinant),
		.inverse_q16(inverse_q16), .status(status), .last_result(last_result)
	);

	bareiss_matrix_inverse_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_ready(in_ready), .matrix_entry(matrix_entry),
		.out_valid(out_valid), .out_ready(out_ready),
		.adjugate_entry(adjugate_entry), .determinant(determinant),
		.inverse_q16(inverse_q16), .status(status), .last_result(last_result),
		.pending(pending), .errors(errors)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= out_idle_pct);

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Leaves valid high on return so that back-to-back entries need no re-raise.
	task automatic put_entry(input int v);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		matrix_entry <= v[11:0];
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Drops valid first, so that the checker has counted the last transaction.
	task automatic set_size(input logic [3:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic put_matrix(input int n, input int span);
		for (int k = 0; k < n * n; k++)
			put_entry($urandom_range(2 * span) - span);
	endtask

	initial begin
		int n, span;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One by one: extremes and a zero determinant.
		set_size(4'd1);
		put_entry(2047);
		put_entry(-2048);
		put_entry(0);
		put_entry(-1);
		// A size of zero behaves as one.
		set_size(4'd0);
		put_entry(5);
		set_size(4'd2);
		put_entry(0); put_entry(1); put_entry(1); put_entry(0);
		put_entry(1); put_entry(1); put_entry(1); put_entry(1);
		put_entry(3); put_entry(1); put_entry(2); put_entry(5);
		// A partial matrix is dropped by the next size write.
		put_entry(7); put_entry(-7);
		set_size(4'd3);
		put_entry(1); put_entry(0); put_entry(0);
		put_entry(0); put_entry(-2048); put_entry(0);
		put_entry(0); put_entry(0); put_entry(2047);
		// Sizes above the maximum act as eight; full-range entries overflow.
		set_size(4'd15);
		put_matrix(8, 2048);

		for (int phase = 0; phase < 3; phase++) begin
			in_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 59 : 0;
			out_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 25 : 0;
			while (sent < 60 * (phase + 1) + 90) begin
				case ($urandom_range(9))
					0: n = 1;
					1: n = $urandom_range(5, 6);
					default: n = $urandom_range(2, 4);
				endcase
				span = ($urandom_range(3) == 0) ? 2048 : $urandom_range(1, 8);
				set_size(n[3:0]);
				put_matrix(n, span);
			end
		end
		set_size(4'd8);
		put_matrix(8, 2);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
